// ===== rtl/csp_pkg.sv =====
// ----------------------------------------------------------------------------
// Compacting string pool package
// Shared constants and request codes for the string pool.
// ----------------------------------------------------------------------------
package csp_pkg;

    localparam int SlotCountDefault = 512;
    localparam int PoolBytesDefault = 16384;

    localparam logic [1:0] REQ_RELEASE = 2'd0;
    localparam logic [1:0] REQ_APPEND  = 2'd1;
    localparam logic [1:0] REQ_READ    = 2'd2;

endpackage

// ===== rtl/compacting_string_pool_core.sv =====
// ----------------------------------------------------------------------------
// Compacting string pool core
// Byte store with a slot table; releases compact the store in place.
// ----------------------------------------------------------------------------
// An append scans the slot table for a free slot on the first byte of a
// string, then stores its bytes; a read fetches the slot entry, then the byte;
// a release moves the bytes above the string down and fixes the slot offsets.
// A sequencer walks the single slot table port; the byte store has one write
// and one read port. Words are taken only when idle with no result pending.
// Synchronous active-low reset, then a clearing pass over the slot table before the first word.
module compacting_string_pool_core
    import csp_pkg::*;
#(
    parameter int SLOT_COUNT = SlotCountDefault,
    parameter int POOL_BYTES = PoolBytesDefault
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [8:0]  s_slot_index,
    input  logic [7:0]  s_char_byte,
    input  logic        s_last_byte,
    input  logic [13:0] s_position,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [8:0]  m_result_slot,
    output logic [7:0]  m_data_byte,
    output logic [13:0] m_text_length
);

    localparam int SW = $clog2(SLOT_COUNT);
    localparam int PW = $clog2(POOL_BYTES);
    localparam int FW = PW + 1;
    localparam int SCW = SW + 1;

    typedef enum logic [11:0] {
        ST_CLEAR = 12'b000000000001,
        ST_IDLE  = 12'b000000000010,
        ST_SCAN  = 12'b000000000100,
        ST_SCANW = 12'b000000001000,
        ST_STORE = 12'b000000010000,
        ST_RDT   = 12'b000000100000,
        ST_RDB   = 12'b000001000000,
        ST_RLT   = 12'b000010000000,
        ST_MVR   = 12'b000100000000,
        ST_MVW   = 12'b001000000000,
        ST_FIXR  = 12'b010000000000,
        ST_FIXW  = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;

    logic [7:0]      store_mem [POOL_BYTES];
    logic [2*FW-1:0] table_mem [SLOT_COUNT];

    logic [7:0]      store_q;
    logic [2*FW-1:0] table_q;
    logic            st_we, tb_we;
    logic [PW-1:0]   st_waddr, st_raddr;
    logic [7:0]      st_wdata;
    logic [SW-1:0]   tb_addr;
    logic [2*FW-1:0] tb_wdata;

    logic [FW-1:0]  fill_reg, fill_next;
    logic [SW-1:0]  build_reg, build_next;
    logic           building_reg, building_next;
    logic [FW-1:0]  cur_len_reg, cur_len_next;
    logic [SCW-1:0] idx_reg, idx_next;
    logic [FW-1:0]  src_reg, src_next;
    logic [FW-1:0]  off_reg, off_next;
    logic [FW-1:0]  len_reg, len_next;
    logic [7:0]     ch_reg, ch_next;
    logic           last_reg, last_next;
    logic [SW-1:0]  slot_reg, slot_next;
    logic [13:0]    pos_reg, pos_next;
    logic           m_valid_reg, m_valid_next;
    logic [8:0]     rs_reg, rs_next;
    logic [7:0]     db_reg, db_next;
    logic [13:0]    tl_reg, tl_next;
    logic           rd_hit_reg, rd_hit_next;

    always_ff @(posedge aclk) begin
        if (st_we) store_mem[st_waddr] <= st_wdata;
        store_q <= store_mem[st_raddr];
        if (tb_we) table_mem[tb_addr] <= tb_wdata;
        table_q <= table_mem[tb_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            fill_reg     <= '0;
            build_reg    <= '0;
            building_reg <= 1'b0;
            idx_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            build_reg    <= build_next;
            building_reg <= building_next;
            idx_reg      <= idx_next;
            m_valid_reg  <= m_valid_next;
        end
        cur_len_reg <= cur_len_next;
        src_reg     <= src_next;
        off_reg     <= off_next;
        len_reg     <= len_next;
        ch_reg      <= ch_next;
        last_reg    <= last_next;
        slot_reg    <= slot_next;
        pos_reg     <= pos_next;
        rs_reg      <= rs_next;
        db_reg      <= db_next;
        tl_reg      <= tl_next;
        rd_hit_reg  <= rd_hit_next;
    end

    assign s_ready       = (state_reg == ST_IDLE) && !m_valid_reg;
    assign m_valid       = m_valid_reg;
    assign m_result_slot = rs_reg;
    assign m_data_byte   = db_reg;
    assign m_text_length = tl_reg;

    logic [FW-1:0] q_off, q_len, rel_end, rel_off, dst, rd_off;
    logic [FW:0]   rd_addr;
    logic          s_slot_ok;
    assign q_off     = table_q[2*FW-1:FW];
    assign q_len     = table_q[FW-1:0];
    assign rel_end   = (q_off + q_len > fill_reg) ? fill_reg : FW'(q_off + q_len);
    assign rel_off   = (q_off > rel_end) ? rel_end : q_off;
    assign dst       = src_reg - len_reg;
    assign rd_off    = rd_hit_reg ? q_off : '0;
    assign rd_addr   = {1'b0, rd_off} + (FW + 1)'(pos_reg);
    assign s_slot_ok = (SLOT_COUNT >= 512) || (s_slot_index < 9'(SLOT_COUNT));

    always_comb begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        build_next    = build_reg;
        building_next = building_reg;
        cur_len_next  = cur_len_reg;
        idx_next      = idx_reg;
        src_next      = src_reg;
        off_next      = off_reg;
        len_next      = len_reg;
        ch_next       = ch_reg;
        last_next     = last_reg;
        slot_next     = slot_reg;
        pos_next      = pos_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        rs_next       = rs_reg;
        db_next       = db_reg;
        tl_next       = tl_reg;
        rd_hit_next   = rd_hit_reg;
        st_we         = 1'b0;
        st_waddr      = fill_reg[PW-1:0];
        st_wdata      = ch_reg;
        st_raddr      = src_reg[PW-1:0];
        tb_we         = 1'b0;
        tb_addr       = idx_reg[SW-1:0];
        tb_wdata      = '0;

        unique case (state_reg)
            ST_CLEAR: begin
                tb_we    = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == SCW'(SLOT_COUNT - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    ch_next   = s_char_byte;
                    last_next = s_last_byte;
                    pos_next  = s_position;
                    slot_next = SW'(s_slot_index);
                    rs_next   = '0;
                    db_next   = '0;
                    tl_next   = '0;
                    case (s_req_type)
                        REQ_RELEASE: begin
                            if (s_slot_index != 9'd0 && s_slot_ok) begin
                                tb_addr    = SW'(s_slot_index);
                                state_next = ST_RLT;
                            end else begin
                                m_valid_next = 1'b1;
                            end
                        end
                        REQ_APPEND: begin
                            if (!building_reg) begin
                                idx_next   = SCW'(1);
                                tb_addr    = SW'(1);
                                state_next = ST_SCAN;
                            end else begin
                                state_next = ST_STORE;
                            end
                        end
                        REQ_READ: begin
                            tb_addr     = SW'(s_slot_index);
                            rd_hit_next = s_slot_ok;
                            state_next  = ST_RDT;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN: begin
                state_next = ST_SCANW;
            end
            ST_SCANW: begin
                if (table_q == '0) begin
                    building_next = 1'b1;
                    build_next    = idx_reg[SW-1:0];
                    cur_len_next  = '0;
                    tb_we         = 1'b1;
                    tb_wdata      = {fill_reg, {FW{1'b0}}};
                    state_next    = ST_STORE;
                end else if (idx_reg == SCW'(SLOT_COUNT - 1)) begin
                    building_next = 1'b1;
                    build_next    = '0;
                    state_next    = ST_STORE;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    tb_addr    = SW'(idx_reg + 1'b1);
                    state_next = ST_SCAN;
                end
            end
            ST_STORE: begin
                tb_addr = build_reg;
                if (build_reg != '0 && fill_reg < FW'(POOL_BYTES)) begin
                    st_we        = 1'b1;
                    fill_next    = fill_reg + 1'b1;
                    cur_len_next = cur_len_reg + 1'b1;
                    tb_we        = 1'b1;
                    tb_wdata     = {FW'(fill_reg - cur_len_reg), FW'(cur_len_reg + 1'b1)};
                end
                if (last_reg) begin
                    rs_next       = 9'(build_reg);
                    building_next = 1'b0;
                    build_next    = '0;
                    m_valid_next  = 1'b1;
                end
                state_next = ST_IDLE;
            end
            ST_RDT: begin
                state_next  = ST_RDB;
                st_raddr    = rd_addr[PW-1:0];
                rd_hit_next = rd_addr < {1'b0, fill_reg};
                tl_next     = (rd_hit_reg && q_len != '0) ? 14'(q_len - 1'b1) : 14'd0;
            end
            ST_RDB: begin
                db_next      = rd_hit_reg ? store_q : 8'd0;
                m_valid_next = 1'b1;
                state_next   = ST_IDLE;
            end
            ST_RLT: begin
                off_next = rel_off;
                len_next = rel_end - rel_off;
                src_next = rel_end;
                tb_addr  = slot_reg;
                tb_we    = 1'b1;
                if (building_reg && build_reg == slot_reg) begin
                    build_next = '0;
                end
                state_next = ST_MVR;
            end
            ST_MVR: begin
                if (src_reg < fill_reg) begin
                    state_next = ST_MVW;
                end else begin
                    fill_next  = fill_reg - len_reg;
                    idx_next   = '0;
                    state_next = ST_FIXR;
                end
            end
            ST_MVW: begin
                st_we      = 1'b1;
                st_waddr   = dst[PW-1:0];
                st_wdata   = store_q;
                src_next   = src_reg + 1'b1;
                st_raddr   = src_reg[PW-1:0] + 1'b1;
                state_next = ST_MVR;
            end
            ST_FIXR: begin
                state_next = ST_FIXW;
            end
            ST_FIXW: begin
                if (q_off > off_reg) begin
                    tb_we    = 1'b1;
                    tb_wdata = {FW'(q_off - len_reg), q_len};
                end
                if (idx_reg == SCW'(SLOT_COUNT - 1)) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_FIXR;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// ===== bench/csp_checker.sv =====
// ----------------------------------------------------------------------------
// String pool checker
// Watches both channels of the string pool, keeps its own copy of the byte
// store and slot table, predicts the result of every accepted word that yields
// one and compares each result word field by field, oldest expectation first.
// ----------------------------------------------------------------------------
module csp_checker
    import csp_pkg::*;
#(
    parameter int SLOT_COUNT = SlotCountDefault,
    parameter int POOL_BYTES = PoolBytesDefault
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [8:0]  s_slot_index,
    input  logic [7:0]  s_char_byte,
    input  logic        s_last_byte,
    input  logic [13:0] s_position,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [8:0]  m_result_slot,
    input  logic [7:0]  m_data_byte,
    input  logic [13:0] m_text_length,
    output int          errors,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [8:0]  result_slot;
        logic [7:0]  data_byte;
        logic [13:0] text_length;
    } pool_result_t;

    logic [7:0]  pool_bytes [POOL_BYTES];
    logic [14:0] slot_base [SLOT_COUNT];
    logic [14:0] slot_size [SLOT_COUNT];
    int unsigned fill;
    int unsigned open_slot;
    bit          open_string;
    pool_result_t awaited_results [$];

    assign pending = awaited_results.size();

    function automatic int unsigned first_free_slot();
        for (int i = 1; i < SLOT_COUNT; i++) begin
            if (slot_base[i] == 0 && slot_size[i] == 0) begin
                return i;
            end
        end
        return 0;
    endfunction

    task automatic free_slot(input int unsigned s);
        int unsigned lo;
        int unsigned hi;
        int unsigned gap;
        lo = slot_base[s];
        hi = lo + slot_size[s];
        if (hi > fill) begin
            hi = fill;
        end
        if (lo > hi) begin
            lo = hi;
        end
        gap = hi - lo;
        for (int unsigned i = hi; i < fill; i++) begin
            pool_bytes[i - gap] = pool_bytes[i];
        end
        fill -= gap;
        slot_base[s] = '0;
        slot_size[s] = '0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (slot_base[i] > lo) begin
                slot_base[i] -= gap;
            end
        end
        if (open_string && open_slot == s) begin
            open_slot = 0;
        end
    endtask

    task automatic predict_word(input logic [1:0] req, input logic [8:0] slot,
                                input logic [7:0] ch, input logic last,
                                input logic [13:0] pos);
        pool_result_t r;
        int unsigned addr;
        int unsigned len;
        r = '0;
        case (req)
            REQ_RELEASE: begin
                if (slot != 0 && slot < SLOT_COUNT) begin
                    free_slot(slot);
                end
                awaited_results.push_back(r);
            end
            REQ_APPEND: begin
                if (!open_string) begin
                    open_string = 1'b1;
                    open_slot = first_free_slot();
                    if (open_slot != 0) begin
                        slot_base[open_slot] = fill;
                        slot_size[open_slot] = '0;
                    end
                end
                if (open_slot != 0 && fill < POOL_BYTES) begin
                    pool_bytes[fill] = ch;
                    fill++;
                    slot_size[open_slot]++;
                end
                if (last) begin
                    r.result_slot = open_slot[8:0];
                    open_string = 1'b0;
                    open_slot = 0;
                    awaited_results.push_back(r);
                end
            end
            REQ_READ: begin
                addr = pos;
                len = 0;
                if (slot < SLOT_COUNT) begin
                    addr = slot_base[slot] + pos;
                    len = slot_size[slot];
                end
                if (addr < fill && addr < POOL_BYTES) begin
                    r.data_byte = pool_bytes[addr];
                end
                r.text_length = (len != 0) ? 14'(len - 1) : 14'd0;
                awaited_results.push_back(r);
            end
            default: begin
            end
        endcase
    endtask

    initial begin
        errors = 0;
        fill = 0;
        open_slot = 0;
        open_string = 1'b0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            slot_base[i] = '0;
            slot_size[i] = '0;
        end
    end

    always @(posedge aclk) begin
        pool_result_t want;
        if (aresetn && s_valid && s_ready) begin
            predict_word(s_req_type, s_slot_index, s_char_byte, s_last_byte, s_position);
        end
        if (aresetn && m_valid && m_ready) begin
            if (awaited_results.size() == 0) begin
                $error("result word with no expectation waiting");
                errors++;
            end else begin
                want = awaited_results.pop_front();
                if (m_result_slot !== want.result_slot) begin
                    $error("result_slot mismatch: expected %0d, got %0d",
                           want.result_slot, m_result_slot);
                    errors++;
                end
                if (m_data_byte !== want.data_byte) begin
                    $error("data_byte mismatch: expected %0d, got %0d",
                           want.data_byte, m_data_byte);
                    errors++;
                end
                if (m_text_length !== want.text_length) begin
                    $error("text_length mismatch: expected %0d, got %0d",
                           want.text_length, m_text_length);
                    errors++;
                end
            end
        end
    end

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// String pool testbench
// Drives directed and random request words into the string pool core under
// several idling patterns and lets the checker judge every result word.
// ----------------------------------------------------------------------------
module testbench;
    import csp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = SlotCountDefault;
    localparam int POOL = PoolBytesDefault;
    localparam int WORD_COUNT = 1050;
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_req_type = REQ_RELEASE;
    logic [8:0]  s_slot_index = '0;
    logic [7:0]  s_char_byte = '0;
    logic        s_last_byte = 1'b0;
    logic [13:0] s_position = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [8:0]  m_result_slot;
    logic [7:0]  m_data_byte;
    logic [13:0] m_text_length;
    int          errors;
    int          pending;
    int          send_gap_pct = 0;
    int          stall_pct = 0;
    int          sent_words = 0;
    int          random_base = 0;

    compacting_string_pool_core dut (.*);

    csp_checker scoreboard (.*);

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    initial begin
        #100ms;
        $display("Some tests failed");
        $finish;
    end

    task automatic send_word(input logic [1:0] req, input logic [8:0] slot,
                             input logic [7:0] ch, input logic last,
                             input logic [13:0] pos);
        if ($urandom_range(99) < send_gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_gap_pct) begin
                @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_req_type <= req;
        s_slot_index <= slot;
        s_char_byte <= ch;
        s_last_byte <= last;
        s_position <= pos;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        sent_words++;
    endtask

    task automatic append_string(input int n);
        for (int i = 0; i < n; i++) begin
            send_word(REQ_APPEND, 9'($urandom), (i == n - 1) ? 8'd0 : 8'($urandom),
                      i == n - 1, 14'($urandom));
        end
    endtask

    task automatic random_word();
        int pick;
        pick = $urandom_range(99);
        if (pick < 8) begin
            send_word(REQ_RELEASE, 9'($urandom), 8'($urandom), 1'($urandom), 14'($urandom));
        end else if (pick < 40) begin
            send_word(REQ_READ, 9'($urandom),
                      8'($urandom), 1'($urandom),
                      ($urandom_range(9) == 0) ? 14'($urandom) : 14'($urandom_range(20)));
        end else if (pick < 97) begin
            append_string(($urandom_range(19) == 0) ? $urandom_range(6, 40)
                                                    : $urandom_range(1, 5));
        end else begin
            send_word(REQ_UNKNOWN, 9'($urandom), 8'($urandom), 1'($urandom), 14'($urandom));
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        send_word(REQ_RELEASE, 9'd0, 8'hff, 1'b1, 14'h3fff);
        send_word(REQ_RELEASE, 9'd511, 8'h00, 1'b0, 14'd0);
        send_word(REQ_READ, 9'd0, 8'h00, 1'b0, 14'd0);
        send_word(REQ_READ, 9'd511, 8'hff, 1'b1, 14'h3fff);
        send_word(REQ_UNKNOWN, 9'h1ff, 8'hff, 1'b1, 14'h3fff);
        send_word(REQ_APPEND, 9'd0, 8'h00, 1'b1, 14'd0);
        send_word(REQ_APPEND, 9'h1ff, 8'hff, 1'b0, 14'h3fff);
        send_word(REQ_APPEND, 9'd0, 8'h80, 1'b0, 14'd0);
        send_word(REQ_APPEND, 9'd0, 8'h00, 1'b1, 14'd0);
        for (int p = 0; p < 4; p++) begin
            send_word(REQ_READ, 9'd2, 8'h00, 1'b0, 14'(p));
        end
        send_word(REQ_READ, 9'd1, 8'h00, 1'b0, 14'd0);
        send_word(REQ_APPEND, 9'd0, 8'h41, 1'b0, 14'd0);
        send_word(REQ_APPEND, 9'd0, 8'h42, 1'b0, 14'd0);
        send_word(REQ_RELEASE, 9'd3, 8'h00, 1'b0, 14'd0);
        send_word(REQ_APPEND, 9'd0, 8'h43, 1'b0, 14'd0);
        send_word(REQ_APPEND, 9'd0, 8'h00, 1'b1, 14'd0);
        send_word(REQ_RELEASE, 9'd1, 8'h00, 1'b0, 14'd0);
        send_word(REQ_READ, 9'd2, 8'h00, 1'b0, 14'd0);
        send_word(REQ_READ, 9'd2, 8'h00, 1'b0, 14'd1);
        send_word(REQ_RELEASE, 9'd2, 8'h00, 1'b0, 14'd0);

        append_string(40);
        send_word(REQ_READ, 9'd1, 8'h00, 1'b0, 14'd0);
        send_word(REQ_READ, 9'd1, 8'h00, 1'b0, 14'h3fff);
        send_word(REQ_READ, 9'd0, 8'h00, 1'b0, 14'h2aaa);
        append_string(2);
        send_word(REQ_RELEASE, 9'd1, 8'h00, 1'b0, 14'd0);
        send_word(REQ_RELEASE, 9'd2, 8'h00, 1'b0, 14'd0);

        for (int i = 1; i < SLOTS; i++) begin
            append_string(1);
        end
        append_string(3);
        send_word(REQ_READ, 9'd511, 8'h00, 1'b0, 14'd0);
        for (int i = 0; i < 64; i++) begin
            send_word(REQ_RELEASE, 9'($urandom_range(1, SLOTS - 1)), 8'h00, 1'b0, 14'd0);
        end

        random_base = sent_words;
        for (int phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: begin send_gap_pct = 0;  stall_pct = 0;  end
                1: begin send_gap_pct = 73; stall_pct = 0;  end
                2: begin send_gap_pct = 0;  stall_pct = 73; end
                default: begin send_gap_pct = 19; stall_pct = 19; end
            endcase
            while (sent_words < random_base + (phase + 1) * (WORD_COUNT - random_base) / 8) begin
                random_word();
            end
        end
        s_valid <= 1'b0;

        while (pending != 0) begin
            @(posedge aclk);
        end
        repeat (2000) @(posedge aclk);
        if (errors == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== compacting_string_pool_core.f =====
rtl/csp_pkg.sv
rtl/compacting_string_pool_core.sv
bench/csp_checker.sv
bench/testbench.sv
